FILE: hdl/clock_page_manager_defines.svh
// assertion macros for clock_page_manager
`ifndef CLOCK_PAGE_MANAGER_DEFINES_SVH
`define CLOCK_PAGE_MANAGER_DEFINES_SVH
`define CPM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CPM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hdl/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg
// types and constants shared by the clock page manager
// ----------------------------------------------------------------------------
package cpm_pkg;
    localparam int RAM_FRAMES_DEF  = 16;
    localparam int VIRT_FRAMES_DEF = 64;
    localparam int PID_BITS_DEF    = 8;

    localparam logic [1:0] CFG_FRAME_SIZE = 2'd0;
    localparam logic [1:0] CFG_RAM_FRAMES = 2'd1;
    localparam logic [1:0] CFG_VIRT_FRAMES = 2'd2;

    localparam logic [2:0] ST_ADMITTED = 3'd0;
    localparam logic [2:0] ST_NO_VMEM  = 3'd1;
    localparam logic [2:0] ST_HIT      = 3'd2;
    localparam logic [2:0] ST_LOADED   = 3'd3;
    localparam logic [2:0] ST_EVICTED  = 3'd4;
    localparam logic [2:0] ST_NO_SPACE = 3'd5;

    typedef struct packed {
        logic        command;
        logic [7:0]  process_id;
        logic [21:0] process_size;
        logic [5:0]  page_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] pages_assigned;
        logic [3:0] ram_frame;
        logic [7:0] evicted_process;
        logic [5:0] evicted_page;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_ADMIT_CHECK, OP_ADMIT_STEP, OP_RSCAN, OP_VSCAN,
        OP_HAND_FIX, OP_SWEEP, OP_FSCAN, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic done;       // current scan/step finished
        logic flag;       // outcome bit of finished step
    } t_status;
endpackage

FILE: hdl/cpm_datapath.sv
// ----------------------------------------------------------------------------
// cpm_datapath
// frame tables, clock hand, scan index and result assembly
// ----------------------------------------------------------------------------
module cpm_datapath #(
    parameter int RAM_FRAMES  = 16,
    parameter int VIRT_FRAMES = 64,
    parameter int PID_BITS    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpm_pkg::t_cmd      i_cmd,
    input  cpm_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output cpm_pkg::t_status   o_status,
    output cpm_pkg::t_out_item o_result
);
    import cpm_pkg::*;

    localparam int RB = $clog2(RAM_FRAMES);
    localparam int VB = $clog2(VIRT_FRAMES);
    localparam int IB = (RB > VB ? RB : VB) + 2;
    localparam logic [15:0] FRAME_SIZE_RST = 16'd4096;

    logic [15:0] r_frame_size;
    logic [4:0]  r_ram_cfg;
    logic [6:0]  r_virt_cfg;

    logic                r_ram_valid [RAM_FRAMES];
    logic [PID_BITS-1:0] r_ram_owner [RAM_FRAMES];
    logic [5:0]          r_ram_page  [RAM_FRAMES];
    logic                r_ram_ref   [RAM_FRAMES];
    logic                r_vvalid    [VIRT_FRAMES];
    logic [PID_BITS-1:0] r_vowner    [VIRT_FRAMES];
    logic [5:0]          r_vpage     [VIRT_FRAMES];
    logic [15:0]         r_vcap      [VIRT_FRAMES];
    logic                r_vcap_ok   [VIRT_FRAMES];  // clear means reset frame size
    logic [6:0]          r_free;
    logic [RB-1:0]       r_hand;
    logic [IB-1:0]       r_idx;

    // registered read of the virtual table at the scan index
    logic [PID_BITS-1:0] r_vrd_owner;
    logic [5:0]          r_vrd_page;
    logic [15:0]         r_vrd_cap;

    logic [PID_BITS-1:0] r_pid;
    logic [5:0]          r_page;
    logic [22:0]         r_size;
    logic [6:0]          r_pages;
    t_out_item           r_res;
    logic                r_done, r_flag;

    logic [IB-1:0] rn, vn;
    always_comb begin
        if (r_ram_cfg == 5'd0) rn = IB'(1);
        else if (32'(r_ram_cfg) > RAM_FRAMES) rn = IB'(RAM_FRAMES);
        else rn = IB'(r_ram_cfg);
        if (r_virt_cfg == 7'd0) vn = IB'(1);
        else if (32'(r_virt_cfg) > VIRT_FRAMES) vn = IB'(VIRT_FRAMES);
        else vn = IB'(r_virt_cfg);
    end

    logic [RB-1:0] ri;
    logic [VB-1:0] vi;
    logic [15:0]   cap_i;
    logic [RB-1:0] hand_nx;
    logic [38:0]   avail;
    assign ri = r_idx[RB-1:0];
    assign vi = r_idx[VB-1:0];
    assign cap_i = r_vcap_ok[vi] ? r_vrd_cap : FRAME_SIZE_RST;
    assign hand_nx = (IB'(r_hand) + IB'(1) < rn) ? r_hand + RB'(1) : '0;
    assign avail = 39'(r_free) * 39'(r_frame_size);

    // the wait cycle after each step reloads these for the new index
    always_ff @(posedge i_clk) begin
        r_vrd_owner <= r_vowner[vi];
        r_vrd_page  <= r_vpage[vi];
        r_vrd_cap   <= r_vcap[vi];
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        r_flag <= 1'b0;
        if (!i_rst_n) begin
            r_frame_size <= FRAME_SIZE_RST;
            r_ram_cfg    <= 5'd16;
            r_virt_cfg   <= 7'd64;
            r_free       <= 7'(VIRT_FRAMES > 64 ? 64 : VIRT_FRAMES);
            r_hand       <= '0;
            for (int k = 0; k < RAM_FRAMES; k++) begin
                r_ram_valid[k] <= 1'b0;
                r_ram_ref[k]   <= 1'b0;
            end
            for (int k = 0; k < VIRT_FRAMES; k++) begin
                r_vvalid[k]  <= 1'b0;
                r_vcap_ok[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_SIZE:  r_frame_size <= i_cfg_data[15:0];
                    CFG_RAM_FRAMES:  r_ram_cfg    <= i_cfg_data[4:0];
                    CFG_VIRT_FRAMES: r_virt_cfg   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_pid   <= PID_BITS'(i_item.process_id);
                    r_page  <= i_item.page_index;
                    r_size  <= {1'b0, i_item.process_size};
                    r_pages <= '0;
                    r_idx   <= '0;
                    r_res   <= '0;
                end
                OP_ADMIT_CHECK: begin
                    r_done <= 1'b1;
                    r_flag <= avail < 39'(r_size);
                    if (avail < 39'(r_size)) r_res.status <= ST_NO_VMEM;
                    else r_res.status <= ST_ADMITTED;
                end
                OP_ADMIT_STEP: begin
                    if (r_idx >= vn || r_size == '0) begin
                        r_done <= 1'b1;
                        r_res.pages_assigned <= r_pages;
                    end else begin
                        if (!r_vvalid[vi]) begin
                            r_vvalid[vi]  <= 1'b1;
                            r_vowner[vi]  <= r_pid;
                            r_vpage[vi]   <= r_pages[5:0];
                            r_pages       <= r_pages + 7'd1;
                            r_vcap_ok[vi] <= 1'b1;
                            if (r_free != '0) r_free <= r_free - 7'd1;
                            if (r_size > 23'(cap_i)) begin
                                r_size     <= r_size - 23'(cap_i);
                                r_vcap[vi] <= '0;
                            end else begin
                                r_vcap[vi] <= cap_i - r_size[15:0];
                                r_size     <= '0;
                            end
                        end
                        r_idx <= r_idx + IB'(1);
                    end
                end
                OP_RSCAN: begin
                    if (r_idx >= rn) begin
                        r_done <= 1'b1;
                        r_idx  <= '0;
                    end else if (r_ram_valid[ri] && r_ram_owner[ri] == r_pid &&
                                 r_ram_page[ri] == r_page) begin
                        r_ram_ref[ri]   <= 1'b1;
                        r_res.status    <= ST_HIT;
                        r_res.ram_frame <= 4'(ri);
                        r_done <= 1'b1;
                        r_flag <= 1'b1;
                    end else begin
                        r_idx <= r_idx + IB'(1);
                    end
                end
                OP_VSCAN: begin
                    if (r_idx >= vn) begin
                        r_done <= 1'b1;
                    end else if (r_vvalid[vi] && r_vrd_owner == r_pid &&
                                 r_vrd_page == r_page) begin
                        r_vvalid[vi]  <= 1'b0;
                        r_vcap[vi]    <= r_frame_size;
                        r_vcap_ok[vi] <= 1'b1;
                        if (r_free != 7'd127) r_free <= r_free + 7'd1;
                        r_done <= 1'b1;
                    end else begin
                        r_idx <= r_idx + IB'(1);
                    end
                end
                OP_HAND_FIX: begin
                    if (IB'(r_hand) >= rn) r_hand <= '0;
                    r_idx  <= '0;
                    r_done <= 1'b1;
                end
                OP_SWEEP: begin
                    // sweep ends on an empty or unreferenced frame
                    if (r_ram_valid[r_hand] && r_ram_ref[r_hand]) begin
                        r_ram_ref[r_hand] <= 1'b0;
                        r_hand <= hand_nx;
                    end else if (r_ram_valid[r_hand]) begin
                        r_done <= 1'b1;
                        r_flag <= 1'b1;
                        r_res.evicted_process <= 8'(r_ram_owner[r_hand]);
                        r_res.evicted_page    <= r_ram_page[r_hand];
                    end else begin
                        r_done <= 1'b1;
                        r_res.status <= ST_LOADED;
                    end
                end
                OP_FSCAN: begin
                    if (r_idx >= vn) begin
                        r_res.status <= ST_NO_SPACE;
                        r_done <= 1'b1;
                    end else if (!r_vvalid[vi]) begin
                        r_vvalid[vi]  <= 1'b1;
                        r_vowner[vi]  <= r_ram_owner[r_hand];
                        r_vpage[vi]   <= r_ram_page[r_hand];
                        r_vcap[vi]    <= '0;
                        r_vcap_ok[vi] <= 1'b1;
                        if (r_free != '0) r_free <= r_free - 7'd1;
                        r_res.status <= ST_EVICTED;
                        r_done <= 1'b1;
                    end else begin
                        r_idx <= r_idx + IB'(1);
                    end
                end
                OP_FINISH: begin
                    r_ram_valid[r_hand] <= 1'b1;
                    r_ram_owner[r_hand] <= r_pid;
                    r_ram_page[r_hand]  <= r_page;
                    r_ram_ref[r_hand]   <= 1'b1;
                    r_res.ram_frame     <= 4'(r_hand);
                    r_hand <= hand_nx;
                    r_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_status.done = r_done;
    assign o_status.flag = r_flag;
    assign o_result = r_res;
endmodule

FILE: hdl/cpm_control.sv
// ----------------------------------------------------------------------------
// cpm_control
// sequencer for admit and access commands, owns the handshakes
// ----------------------------------------------------------------------------
module cpm_control (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_command,
    input  logic             i_out_ready,
    input  cpm_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output cpm_pkg::t_cmd    o_cmd
);
    import cpm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_ACHK, S_ASTEP, S_RSCAN, S_VSCAN, S_HFIX, S_SWEEP,
        S_FSCAN, S_FIN, S_WAIT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_cmd_acc;
    logic   r_out_valid;

    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_ACHK:  o_cmd.op = OP_ADMIT_CHECK;
            S_ASTEP: o_cmd.op = OP_ADMIT_STEP;
            S_RSCAN: o_cmd.op = OP_RSCAN;
            S_VSCAN: o_cmd.op = OP_VSCAN;
            S_HFIX:  o_cmd.op = OP_HAND_FIX;
            S_SWEEP: o_cmd.op = OP_SWEEP;
            S_FSCAN: o_cmd.op = OP_FSCAN;
            S_FIN:   o_cmd.op = OP_FINISH;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    // each op state runs its op, and the wait state after it sees its done flag
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE: n_state = r_cmd_acc ? S_RSCAN : S_ACHK;
            S_ACHK:   n_state = S_WAIT;
            S_ASTEP, S_RSCAN, S_VSCAN, S_SWEEP, S_FSCAN, S_HFIX:
                n_state = S_WAIT;
            S_FIN:    n_state = S_WAIT;
            S_WAIT:   n_state = S_WAIT;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    t_state r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= S_IDLE;
            r_cmd_acc   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_IDLE && i_in_valid) r_cmd_acc <= i_command;
            if (r_state != S_WAIT) r_prev <= r_state;
            if (r_state == S_WAIT) begin
                if (!i_status.done) begin
                    r_state <= r_prev;
                end else begin
                    priority case (r_prev)
                        S_ACHK:  r_state <= i_status.flag ? S_OUT : S_ASTEP;
                        S_ASTEP: r_state <= S_OUT;
                        S_RSCAN: r_state <= i_status.flag ? S_OUT : S_VSCAN;
                        S_VSCAN: r_state <= S_HFIX;
                        S_HFIX:  r_state <= S_SWEEP;
                        S_SWEEP: r_state <= i_status.flag ? S_FSCAN : S_FIN;
                        S_FSCAN: r_state <= S_FIN;
                        default: r_state <= S_OUT;
                    endcase
                    if (r_prev == S_FIN || r_prev == S_ASTEP ||
                        ((r_prev == S_ACHK || r_prev == S_RSCAN) && i_status.flag))
                        r_out_valid <= 1'b1;
                end
            end else begin
                r_state <= n_state;
                if (r_state == S_OUT && i_out_ready) r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

FILE: hdl/clock_page_manager.sv
// ----------------------------------------------------------------------------
// clock_page_manager
// second-chance page replacement over RAM and virtual frame tables
// ----------------------------------------------------------------------------
// input channel takes one command item (admit or access); output channel
// returns exactly one result item per command, in order.
// an item runs alone: each table step is an op state and then a wait state
// that checks it; the wait state also loads the next virtual table entry.
// admit: a capacity check, then a virtual frame scan; access: RAM search,
// virtual search, up to RAM_FRAMES+1 hand steps and a free frame search;
// the scans look at one table entry per step.
// a result holds on the output until taken; no new item is accepted while
// the result waits. configuration is written any time the block is idle.
// reset clears valid and reference bits and the clock hand and sets the
// free count to VIRT_FRAMES (at most 64); no clearing pass is needed.
module clock_page_manager
    import cpm_pkg::*;
#(
    parameter int RAM_FRAMES  = RAM_FRAMES_DEF,
    parameter int VIRT_FRAMES = VIRT_FRAMES_DEF,
    parameter int PID_BITS    = PID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cpm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cpm_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    cpm_control u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_command(i_in_data.command), .i_out_ready,
        .i_status(w_status), .o_in_ready, .o_out_valid, .o_cmd(w_cmd)
    );

    cpm_datapath #(
        .RAM_FRAMES(RAM_FRAMES), .VIRT_FRAMES(VIRT_FRAMES), .PID_BITS(PID_BITS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_item(i_in_data),
        .i_cfg_we(i_cfg_valid), .i_cfg_index, .i_cfg_data,
        .o_status(w_status), .o_result(o_out_data)
    );
endmodule

FILE: hdl/cpm_checker.sv
// ----------------------------------------------------------------------------
// cpm_checker
// port-level checks for the clock page manager
// ----------------------------------------------------------------------------
`include "clock_page_manager_defines.svh"
module cpm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cpm_pkg::t_out_item o_out_data
);
    import cpm_pkg::*;
    // one item at a time: no accept while a result is pending
    `CPM_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `CPM_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_out_valid, o_out_data.status <= ST_NO_SPACE)
    `CPM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `CPM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule

bind clock_page_manager cpm_checker u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
    .o_out_data
);
